// File: hdl/gcsd_pkg.sv
// Shared types, constants and helpers for the gauge command, stepper and display block.
`timescale 1ns / 1ps
package gcsd_pkg;

  // Display geometry
  localparam int DISPLAY_COLUMNS = 13;
  localparam int CHAR_DEPTH      = 2 * DISPLAY_COLUMNS;
  localparam int CHAR_AW         = $clog2(CHAR_DEPTH);
  localparam int COL_W           = $clog2(DISPLAY_COLUMNS + 1);

  // Stepper phases
  localparam int PHASES  = 6;
  localparam int PHASE_W = $clog2(PHASES);
  localparam int TABLE_W = 8 * PHASES;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = TABLE_W;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TABLE_A = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TABLE_B = 1'd1;

  // Input item kinds
  localparam logic [1:0] FUNC_SERIAL  = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_DISPLAY = 2'd2;

  // Result kinds
  localparam logic OUT_KIND_STEP = 1'b0;
  localparam logic OUT_KIND_LCD  = 1'b1;

  // Frame bytes and commands
  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [7:0] CMD_TARGET_A = 8'h01;
  localparam logic [7:0] CMD_TARGET_B = 8'h02;
  localparam logic [7:0] CMD_CHAR     = 8'h03;
  localparam logic [1:0] FRAME_LAST   = 2'd3;

  // LCD row address bytes
  localparam logic [7:0] ROW0_ADDR = 8'h80;
  localparam logic [7:0] ROW1_ADDR = 8'hC0;

  // Decoded frame, applied in the cycle its last byte is accepted
  typedef struct packed {
    logic               tgt_a_we;
    logic               tgt_b_we;
    logic [15:0]        tgt_word;
    logic               char_we;
    logic [CHAR_AW-1:0] char_addr;
    logic [7:0]         char_data;
  } frame_cmd_t;

  function automatic logic [7:0] phase_byte(input logic [TABLE_W-1:0] tbl,
                                            input logic [PHASE_W-1:0] k);
    logic [TABLE_W-1:0] sh;
    sh = tbl >> {k, 3'b000};
    return sh[7:0];
  endfunction

endpackage

// File: hdl/gcsd_in_if.sv
// Input channel: item kind and received serial byte.
`timescale 1ns / 1ps
interface gcsd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

// File: hdl/gcsd_out_if.sv
// Output channel: stepper drive bytes and LCD writes.
`timescale 1ns / 1ps
interface gcsd_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_value;
  logic       lcd_is_data;

  modport source (output valid, output out_kind, output out_value, output lcd_is_data,
                  input ready);
  modport sink (input valid, input out_kind, input out_value, input lcd_is_data,
                output ready);
endinterface

// File: hdl/gauge_command_stepper_display.sv
// Top level: item decode, result stage and output register of the gauge/display block.
`timescale 1ns / 1ps
// One input item is taken every cycle while the output side keeps up. A tick or a
// display poll gives its result through the result stage, which waits on the
// registered read of the character RAM, and then through the output register.
// Serial bytes and unused item kinds give no result. Up to two results can wait
// inside the block, so a stalled output only stops input once both are full.
// Character RAM entries that were never written read as zero through per-entry
// written flags cleared at reset; there is no clearing pass.
module gauge_command_stepper_display (
  input  logic                             clk,
  input  logic                             rst,
  gcsd_in_if.sink                          in_ch,
  gcsd_out_if.source                       out_ch,
  input  logic                             cfg_wen,
  input  logic [gcsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gcsd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                 in_acc;
  logic                 tick, poll, byte_en;
  gcsd_pkg::frame_cmd_t cmd;
  logic [7:0]           drive;
  logic                 disp_is_data;
  logic [7:0]           disp_ctrl;
  logic [7:0]           disp_char;

  // result stage (waits on RAM data)
  logic       s1_valid;
  logic       s1_kind;
  logic       s1_is_data;
  logic [7:0] s1_value;
  logic       s1_advance;

  // output register
  logic       o_valid;
  logic       o_kind;
  logic       o_is_data;
  logic [7:0] o_value;

  assign s1_advance  = s1_valid && (!o_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_advance;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign byte_en     = in_acc && (in_ch.func == gcsd_pkg::FUNC_SERIAL);
  assign tick        = in_acc && (in_ch.func == gcsd_pkg::FUNC_TICK);
  assign poll        = in_acc && (in_ch.func == gcsd_pkg::FUNC_DISPLAY);

  gcsd_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .byte_en (byte_en),
    .rx_byte (in_ch.rx_byte),
    .cmd     (cmd)
  );

  gcsd_stepper u_stepper (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .tick      (tick),
    .drive     (drive)
  );

  gcsd_display u_display (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .poll      (poll),
    .is_data   (disp_is_data),
    .ctrl_byte (disp_ctrl),
    .char_byte (disp_char)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid <= tick || poll;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind    <= poll ? gcsd_pkg::OUT_KIND_LCD : gcsd_pkg::OUT_KIND_STEP;
      s1_is_data <= poll && disp_is_data;
      s1_value   <= poll ? disp_ctrl : drive;
    end
    if (s1_advance) begin
      o_kind    <= s1_kind;
      o_is_data <= s1_is_data;
      o_value   <= s1_is_data ? disp_char : s1_value;
    end
  end

  assign out_ch.valid       = o_valid;
  assign out_ch.out_kind    = o_kind;
  assign out_ch.out_value   = o_value;
  assign out_ch.lcd_is_data = o_is_data;

  a_serial_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.func == gcsd_pkg::FUNC_SERIAL) |=> !s1_valid)
    else $error("serial beat produced a result");

  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    tick |=> s1_valid && s1_kind == gcsd_pkg::OUT_KIND_STEP && !s1_is_data)
    else $error("tick did not queue a stepper result");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> s1_valid && $stable(s1_value))
    else $error("stalled result stage lost its item");

  a_step_not_data: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_kind == gcsd_pkg::OUT_KIND_STEP) |-> !o_is_data)
    else $error("stepper result flagged as LCD data");

endmodule

// File: hdl/gcsd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module gcsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/gcsd_frame.sv
// Serial frame assembler: collects command frames and decodes the fourth byte.
`timescale 1ns / 1ps
module gcsd_frame (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_en,
  input  logic [7:0]          rx_byte,
  output gcsd_pkg::frame_cmd_t cmd
);

  logic [1:0] frame_pos;
  logic [1:0] frame_pos_next;
  logic [1:0] pos_eff;
  logic [7:0] cmd_byte;     // frame byte 1
  logic [7:0] operand_hi;   // frame byte 2
  logic       apply;

  // sync byte restarts the frame before it is placed
  assign pos_eff = (rx_byte == gcsd_pkg::SYNC_BYTE) ? 2'd0 : frame_pos;
  assign apply   = byte_en && (pos_eff == gcsd_pkg::FRAME_LAST);

  always_comb begin
    frame_pos_next = frame_pos;
    if (byte_en) begin
      frame_pos_next = apply ? 2'd0 : pos_eff + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos <= 2'd0;
    end else begin
      frame_pos <= frame_pos_next;
    end
  end

  // byte 0 is only a marker and is not kept
  always_ff @(posedge clk) begin
    if (byte_en && pos_eff == 2'd1) begin
      cmd_byte <= rx_byte;
    end
    if (byte_en && pos_eff == 2'd2) begin
      operand_hi <= rx_byte;
    end
  end

  always_comb begin
    cmd.tgt_a_we  = apply && (cmd_byte == gcsd_pkg::CMD_TARGET_A);
    cmd.tgt_b_we  = apply && (cmd_byte == gcsd_pkg::CMD_TARGET_B);
    cmd.tgt_word  = {operand_hi, rx_byte};
    cmd.char_we   = apply && (cmd_byte == gcsd_pkg::CMD_CHAR) &&
                    (operand_hi < 8'(gcsd_pkg::DISPLAY_COLUMNS));
    cmd.char_addr = gcsd_pkg::CHAR_AW'(operand_hi);
    cmd.char_data = rx_byte;
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.tgt_a_we, cmd.tgt_b_we, cmd.char_we}) <= 1)
    else $error("frame decoded to more than one command");

  a_apply_restarts: assert property (@(posedge clk) disable iff (rst)
    apply |=> frame_pos == 2'd0)
    else $error("frame position not cleared after apply");

  a_cmd_needs_byte: assert property (@(posedge clk) disable iff (rst)
    (cmd.tgt_a_we || cmd.tgt_b_we || cmd.char_we) |-> byte_en)
    else $error("frame command without a serial beat");

endmodule

// File: hdl/gcsd_stepper.sv
// Gauge stepper: targets, positions, phase counters and drive pattern lookup.
`timescale 1ns / 1ps
module gcsd_stepper (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [gcsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gcsd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  gcsd_pkg::frame_cmd_t                 cmd,
  input  logic                                 tick,
  output logic [7:0]                           drive
);

  logic [gcsd_pkg::TABLE_W-1:0] phase_table_a;
  logic [gcsd_pkg::TABLE_W-1:0] phase_table_b;
  logic [15:0]                  position_a, position_b;
  logic [15:0]                  position_a_next, position_b_next;
  logic [15:0]                  target_a, target_b;
  logic [gcsd_pkg::PHASE_W-1:0] phase_a, phase_b;
  logic [gcsd_pkg::PHASE_W-1:0] phase_a_next, phase_b_next;

  localparam logic [gcsd_pkg::PHASE_W-1:0] PHASE_MAX = gcsd_pkg::PHASE_W'(gcsd_pkg::PHASES - 1);

  // phase tracks position mod 6 so no divider is needed
  always_comb begin
    position_a_next = position_a;
    phase_a_next    = phase_a;
    if (position_a < target_a) begin
      position_a_next = position_a + 16'd1;
      phase_a_next    = (phase_a == PHASE_MAX) ? '0 : phase_a + 1'b1;
    end else if (position_a > target_a) begin
      position_a_next = position_a - 16'd1;
      phase_a_next    = (phase_a == '0) ? PHASE_MAX : phase_a - 1'b1;
    end
  end

  always_comb begin
    position_b_next = position_b;
    phase_b_next    = phase_b;
    if (position_b < target_b) begin
      position_b_next = position_b + 16'd1;
      phase_b_next    = (phase_b == PHASE_MAX) ? '0 : phase_b + 1'b1;
    end else if (position_b > target_b) begin
      position_b_next = position_b - 16'd1;
      phase_b_next    = (phase_b == '0) ? PHASE_MAX : phase_b - 1'b1;
    end
  end

  assign drive = gcsd_pkg::phase_byte(phase_table_a, phase_a_next) |
                 gcsd_pkg::phase_byte(phase_table_b, phase_b_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_table_a <= '0;
      phase_table_b <= '0;
      position_a    <= '0;
      position_b    <= '0;
      target_a      <= '0;
      target_b      <= '0;
      phase_a       <= '0;
      phase_b       <= '0;
    end else begin
      if (cfg_wen && cfg_index == gcsd_pkg::REG_PHASE_TABLE_A) begin
        phase_table_a <= cfg_data;
      end
      if (cfg_wen && cfg_index == gcsd_pkg::REG_PHASE_TABLE_B) begin
        phase_table_b <= cfg_data;
      end
      if (cmd.tgt_a_we) begin
        target_a <= cmd.tgt_word;
      end
      if (cmd.tgt_b_we) begin
        target_b <= cmd.tgt_word;
      end
      if (tick) begin
        position_a <= position_a_next;
        position_b <= position_b_next;
        phase_a    <= phase_a_next;
        phase_b    <= phase_b_next;
      end
    end
  end

  a_phase_a_range: assert property (@(posedge clk) disable iff (rst)
    phase_a <= PHASE_MAX && phase_b <= PHASE_MAX)
    else $error("phase counter out of range");

  a_phase_follows: assert property (@(posedge clk) disable iff (rst)
    (tick && position_a != target_a) |=> phase_a != $past(phase_a))
    else $error("gauge A moved without phase change");

  a_hold_no_tick: assert property (@(posedge clk) disable iff (rst)
    !tick |=> $stable(position_a) && $stable(position_b))
    else $error("position changed without a tick");

endmodule

// File: hdl/gcsd_display.sv
// LCD scan sequencer with character RAM and per-entry written flags.
`timescale 1ns / 1ps
module gcsd_display (
  input  logic                 clk,
  input  logic                 rst,
  input  gcsd_pkg::frame_cmd_t cmd,
  input  logic                 poll,
  output logic                 is_data,
  output logic [7:0]           ctrl_byte,
  output logic [7:0]           char_byte
);

  localparam logic [gcsd_pkg::COL_W-1:0] LAST_COL = gcsd_pkg::COL_W'(gcsd_pkg::DISPLAY_COLUMNS);

  logic [gcsd_pkg::COL_W-1:0]    scan_column;
  logic                          scan_row;
  logic [gcsd_pkg::CHAR_AW-1:0]  row_base;
  logic [gcsd_pkg::CHAR_AW-1:0]  rd_addr;
  logic                          rd_en;
  logic [gcsd_pkg::CHAR_DEPTH-1:0] written;
  logic                          rd_written;
  logic [7:0]                    ram_q;

  assign is_data   = (scan_column != '0);
  assign ctrl_byte = scan_row ? gcsd_pkg::ROW1_ADDR : gcsd_pkg::ROW0_ADDR;
  assign row_base  = scan_row ? gcsd_pkg::CHAR_AW'(gcsd_pkg::DISPLAY_COLUMNS) : '0;
  assign rd_addr   = row_base + gcsd_pkg::CHAR_AW'(scan_column - 1'b1);
  assign rd_en     = poll && is_data;

  gcsd_ram #(
    .WIDTH (8),
    .DEPTH (gcsd_pkg::CHAR_DEPTH)
  ) u_char_ram (
    .clk   (clk),
    .we    (cmd.char_we),
    .waddr (cmd.char_addr),
    .wdata (cmd.char_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // unwritten entries read as blank (zero)
  assign char_byte = rd_written ? ram_q : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_column <= '0;
      scan_row    <= 1'b0;
      written     <= '0;
      rd_written  <= 1'b0;
    end else begin
      if (cmd.char_we) begin
        written[cmd.char_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
      if (poll) begin
        if (scan_column == LAST_COL) begin
          scan_column <= '0;
          scan_row    <= ~scan_row;
        end else begin
          scan_column <= scan_column + 1'b1;
        end
      end
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(poll && cmd.char_we))
    else $error("character write and scan read in the same cycle");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    scan_column <= LAST_COL)
    else $error("scan column out of range");

  a_row_flip: assert property (@(posedge clk) disable iff (rst)
    (poll && scan_column == LAST_COL) |=> scan_row != $past(scan_row))
    else $error("row did not flip at end of row scan");

endmodule

// File: tb/sv/gauge_command_stepper_display_tb.sv
// Self-checking testbench for the gauge command, stepper and display block.
`timescale 1ns / 1ps
module gauge_command_stepper_display_tb;
  import gcsd_pkg::*;

  localparam int CLK_PERIOD      = 4;
  localparam int RESET_CYCLES    = 6;
  localparam int MAX_GAP         = 17;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int PHASE_ITEMS     = 210;
  localparam int RANDOM_PHASES   = 5;
  localparam int DIRECTED_ROWS   = 25;

  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam logic [7:0] CMD_UNDEFINED = 8'h09;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_value;
    logic       lcd_is_data;
  } drive_beat_t;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  rx;
    bit          fixed;
    drive_beat_t beat;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  gcsd_in_if  in_ch ();
  gcsd_out_if out_ch ();

  gauge_command_stepper_display DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state
  logic [TABLE_W-1:0] pattern_a = '0;
  logic [TABLE_W-1:0] pattern_b = '0;
  logic [1:0]         frame_pos = '0;
  logic [7:0]         frame_bytes [3] = '{default: 8'h00};
  logic [15:0]        pos_a = '0;
  logic [15:0]        pos_b = '0;
  logic [15:0]        target_a = '0;
  logic [15:0]        target_b = '0;
  logic [3:0]         scan_col = '0;
  logic               scan_row = 1'b0;
  logic [7:0]         lcd_chars [CHAR_DEPTH] = '{default: 8'h00};

  drive_beat_t due_beats [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          sender_burst = 1'b0;
  bit          sink_burst = 1'b0;
  bit          long_hold_req = 1'b0;
  stim_row_t   directed [DIRECTED_ROWS];

  function automatic logic [15:0] nudge(input logic [15:0] pos, input logic [15:0] tgt);
    if (pos < tgt) return pos + 16'd1;
    if (pos > tgt) return pos - 16'd1;
    return pos;
  endfunction

  function automatic logic [7:0] phase_drive(input logic [TABLE_W-1:0] pattern,
                                             input logic [15:0] pos);
    int k;
    k = int'(pos % PHASES);
    return pattern[8*k +: 8];
  endfunction

  // Updates the predicted state for one accepted item; returns 1 when it owes a beat.
  function automatic bit gauge_display_step(input logic [1:0] func, input logic [7:0] rx,
                                            output drive_beat_t beat);
    bit produced;
    int idx;
    produced = 1'b0;
    beat = '0;
    case (func)
      FUNC_SERIAL: begin
        if (rx == SYNC_BYTE) frame_pos = '0;
        if (frame_pos < FRAME_LAST) begin
          frame_bytes[frame_pos] = rx;
          frame_pos = frame_pos + 2'd1;
        end else begin
          if (frame_bytes[1] == CMD_TARGET_A) target_a = {frame_bytes[2], rx};
          else if (frame_bytes[1] == CMD_TARGET_B) target_b = {frame_bytes[2], rx};
          else if (frame_bytes[1] == CMD_CHAR && frame_bytes[2] < DISPLAY_COLUMNS)
            lcd_chars[frame_bytes[2]] = rx;
          frame_pos = '0;
        end
      end
      FUNC_TICK: begin
        pos_a = nudge(pos_a, target_a);
        pos_b = nudge(pos_b, target_b);
        beat.out_kind    = OUT_KIND_STEP;
        beat.out_value   = phase_drive(pattern_a, pos_a) | phase_drive(pattern_b, pos_b);
        beat.lcd_is_data = 1'b0;
        produced = 1'b1;
      end
      FUNC_DISPLAY: begin
        beat.out_kind = OUT_KIND_LCD;
        if (scan_col == 0) begin
          beat.out_value   = scan_row ? ROW1_ADDR : ROW0_ADDR;
          beat.lcd_is_data = 1'b0;
        end else begin
          idx = int'(scan_row) * DISPLAY_COLUMNS + int'(scan_col) - 1;
          beat.out_value   = lcd_chars[idx];
          beat.lcd_is_data = 1'b1;
        end
        if (scan_col == DISPLAY_COLUMNS) begin
          scan_col = '0;
          scan_row = ~scan_row;
        end else begin
          scan_col = scan_col + 4'd1;
        end
        produced = 1'b1;
      end
      default: ;
    endcase
    return produced;
  endfunction

  // Entered and left at a falling edge.
  task automatic offer(input logic [1:0] func, input logic [7:0] rx, input bit fixed,
                       input drive_beat_t fixed_beat);
    int          gap;
    drive_beat_t beat;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.func    = func;
    in_ch.rx_byte = rx;
    do @(posedge clk); while (!in_ch.ready);
    if (gauge_display_step(func, rx, beat)) due_beats.push_back(fixed ? fixed_beat : beat);
    @(negedge clk);
  endtask

  task automatic load_pattern(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
    cfg_wen   = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wen = 1'b0;
    if (idx == REG_PHASE_TABLE_A) pattern_a = val;
    else pattern_b = val;
  endtask

  // Lets every owed beat drain, then lets any frame still in flight settle.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic offer_random_unit(inout int sent);
    int         pick;
    int         extra;
    logic [7:0] cmd;
    logic [7:0] hi;
    logic [7:0] lo;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // well-formed frame, random content
      if ($urandom_range(0, 6) == 0) begin
        cmd = 8'($urandom_range(0, 254));
      end else begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_TARGET_A;
          1:       cmd = CMD_TARGET_B;
          default: cmd = CMD_CHAR;
        endcase
      end
      if (cmd == CMD_CHAR)
        hi = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 254)) : 8'($urandom_range(0, 15));
      else
        hi = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 254)) : 8'($urandom_range(0, 1));
      lo = 8'($urandom_range(0, 254));
      offer(FUNC_SERIAL, SYNC_BYTE, 1'b0, '0);
      offer(FUNC_SERIAL, cmd, 1'b0, '0);
      offer(FUNC_SERIAL, hi, 1'b0, '0);
      offer(FUNC_SERIAL, lo, 1'b0, '0);
      sent += 4;
    end else if (pick < 38) begin
      offer(FUNC_SERIAL, 8'($urandom_range(0, 255)), 1'b0, '0);
      sent += 1;
    end else if (pick < 41) begin
      // truncated frame, next sync cuts it off
      extra = $urandom_range(1, 2);
      offer(FUNC_SERIAL, SYNC_BYTE, 1'b0, '0);
      repeat (extra) offer(FUNC_SERIAL, 8'($urandom_range(0, 254)), 1'b0, '0);
      sent += 1 + extra;
    end else if (pick < 43) begin
      offer(FUNC_UNUSED, 8'($urandom_range(0, 255)), 1'b0, '0);
    end else if (pick < 72) begin
      offer(FUNC_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
      sent += 1;
    end else begin
      offer(FUNC_DISPLAY, 8'($urandom_range(0, 255)), 1'b0, '0);
      sent += 1;
    end
  endtask

  // Output side: random stalls per beat, one long hold on request.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    drive_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (due_beats.size() == 0) begin
        $error("unexpected beat: out_kind %0d out_value %02h lcd_is_data %0d",
               out_ch.out_kind, out_ch.out_value, out_ch.lcd_is_data);
        mismatches++;
      end else begin
        want = due_beats.pop_front();
        if (out_ch.out_kind !== want.out_kind) begin
          $error("out_kind: expected %0d, got %0d", want.out_kind, out_ch.out_kind);
          mismatches++;
        end
        if (out_ch.out_value !== want.out_value) begin
          $error("out_value: expected %02h, got %02h", want.out_value, out_ch.out_value);
          mismatches++;
        end
        if (out_ch.lcd_is_data !== want.lcd_is_data) begin
          $error("lcd_is_data: expected %0d, got %0d", want.lcd_is_data, out_ch.lcd_is_data);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("gauge_command_stepper_display: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                 row;
    int                 phase;
    int                 sent;
    logic [TABLE_W-1:0] set_a;
    logic [TABLE_W-1:0] set_b;

    rst           = 1'b1;
    cfg_wen       = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_SERIAL;
    in_ch.rx_byte = 8'h00;

    // pattern A entry k is 1 << k, pattern B all zero
    directed = '{
      '{FUNC_DISPLAY, 8'h00, 1'b1, {OUT_KIND_LCD, ROW0_ADDR, 1'b0}},
      '{FUNC_DISPLAY, 8'hFF, 1'b1, {OUT_KIND_LCD, 8'h00, 1'b1}},
      '{FUNC_TICK,    8'hFF, 1'b1, {OUT_KIND_STEP, 8'h01, 1'b0}},
      '{FUNC_UNUSED,  8'hA5, 1'b0, '0},
      // char at last column
      '{FUNC_SERIAL, SYNC_BYTE, 1'b0, '0},
      '{FUNC_SERIAL, CMD_CHAR,  1'b0, '0},
      '{FUNC_SERIAL, 8'h0C,     1'b0, '0},
      '{FUNC_SERIAL, 8'h7E,     1'b0, '0},
      // column past the row: dropped
      '{FUNC_SERIAL, SYNC_BYTE, 1'b0, '0},
      '{FUNC_SERIAL, CMD_CHAR,  1'b0, '0},
      '{FUNC_SERIAL, 8'h0D,     1'b0, '0},
      '{FUNC_SERIAL, 8'h55,     1'b0, '0},
      // undefined command cut short by a resync, then target A = 2
      '{FUNC_SERIAL, SYNC_BYTE,     1'b0, '0},
      '{FUNC_SERIAL, CMD_UNDEFINED, 1'b0, '0},
      '{FUNC_SERIAL, SYNC_BYTE,     1'b0, '0},
      '{FUNC_SERIAL, CMD_TARGET_A,  1'b0, '0},
      '{FUNC_SERIAL, 8'h00,         1'b0, '0},
      '{FUNC_SERIAL, 8'h02,         1'b0, '0},
      // target B = 0xFE00, its high byte the largest that is not a sync byte
      '{FUNC_SERIAL, SYNC_BYTE,    1'b0, '0},
      '{FUNC_SERIAL, CMD_TARGET_B, 1'b0, '0},
      '{FUNC_SERIAL, 8'hFE,        1'b0, '0},
      '{FUNC_SERIAL, 8'h00,        1'b0, '0},
      '{FUNC_TICK, 8'h00, 1'b1, {OUT_KIND_STEP, 8'h02, 1'b0}},
      '{FUNC_TICK, 8'h00, 1'b1, {OUT_KIND_STEP, 8'h04, 1'b0}},
      // A parked on its target
      '{FUNC_TICK, 8'h00, 1'b1, {OUT_KIND_STEP, 8'h04, 1'b0}}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    load_pattern(REG_PHASE_TABLE_A, 48'h20_10_08_04_02_01);
    load_pattern(REG_PHASE_TABLE_B, '0);
    for (row = 0; row < DIRECTED_ROWS; row++)
      offer(directed[row].func, directed[row].rx, directed[row].fixed, directed[row].beat);

    for (phase = 1; phase <= RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        1: begin
          set_a = '1;
          set_b = '0;
        end
        3: begin
          set_a = '0;
          set_b = '1;
        end
        5: begin
          set_a = 48'hAAAA_AAAA_AAAA;
          set_b = 48'h5555_5555_5555;
        end
        default: begin
          set_a = {16'($urandom), 32'($urandom)};
          set_b = {16'($urandom), 32'($urandom)};
        end
      endcase
      load_pattern(REG_PHASE_TABLE_A, set_a);
      load_pattern(REG_PHASE_TABLE_B, set_b);
      if (phase == 2) begin
        // back up the output and keep offering until the input stalls
        long_hold_req = 1'b1;
        sender_burst  = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) offer_random_unit(sent);
    end

    settle();
    if (mismatches == 0) begin
      $display("gauge_command_stepper_display: match");
    end else begin
      $display("gauge_command_stepper_display: mismatch");
    end
    $finish;
  end

endmodule

// File: gauge_command_stepper_display.f
hdl/gcsd_pkg.sv
hdl/gcsd_in_if.sv
hdl/gcsd_out_if.sv
hdl/gcsd_ram.sv
hdl/gcsd_frame.sv
hdl/gcsd_stepper.sv
hdl/gcsd_display.sv
hdl/gauge_command_stepper_display.sv
tb/sv/gauge_command_stepper_display_tb.sv
